// ----- hdl/color_space_quantizer_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the colour space quantiser
// Clocked on clock, switched off while reset is high.
// ---------------------------------------------------------------------------
`ifndef COLOR_SPACE_QUANTIZER_UNIT_ASSERT_SVH
`define COLOR_SPACE_QUANTIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define CSQ_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("csq: same-cycle check failed");

// next-cycle implication
`define CSQ_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("csq: next-cycle check failed");

`endif

// ----- hdl/csq_pkg.sv -----
// ---------------------------------------------------------------------------
// csq_pkg
// Types, register codes and colour matrices for the colour space quantiser.
// ---------------------------------------------------------------------------
`default_nettype none

package csq_pkg;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } csq_req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } csq_rsp_type;

   localparam logic [1:0] MODE_RGB = 2'd0;
   localparam logic [1:0] MODE_YUV = 2'd1;
   localparam logic [1:0] MODE_YIQ = 2'd2;

   localparam logic [1:0] CSR_COLOR_MODE = 2'd0;
   localparam logic [1:0] CSR_LEVELS     = 2'd1;

   localparam int SW = 9;    // luma step width (1..256)
   localparam int DW = 17;   // Q9.8 step width
   localparam int MW = 23;   // reciprocal width
   localparam int RECIP_SHIFT = 30;

   typedef struct packed {
      logic                  busy;
      logic [1:0]            mode;
      logic [SW-1:0]         step;
      logic [2:0][DW-1:0]    div;
      logic [2:0][MW-1:0]    recip;
   } csq_cfg_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_DIV,
      ST_IDLE
   } csq_state_type;

   // chroma ranges in hundredths, [yiq][chroma]
   localparam int RANGE_TAB [2][2] = '{'{22236, 31365}, '{30396, 26622}};
   localparam int HALF_TAB  [2][2] = '{
      '{(22236 * 128 + 50) / 100, (31365 * 128 + 50) / 100},
      '{(30396 * 128 + 50) / 100, (26622 * 128 + 50) / 100}};

   // matrices in thousandths, [yiq][row][col]
   localparam int FWD_TAB [2][3][3] = '{
      '{'{299, 587, 114}, '{-147, -289, 436}, '{615, -515, -100}},
      '{'{299, 587, 114}, '{596, -274, -322}, '{211, -522, 311}}};
   localparam int INV_TAB [2][3][3] = '{
      '{'{1000, 0, 1140}, '{1000, -395, -581}, '{1000, 2032, 0}},
      '{'{1000, 956, 621}, '{1000, -272, -649}, '{1000, -1106, 1703}}};

   // thousandths to fixed point, ties away from zero
   function automatic int coef_fix(input int k, input int frac);
      int mag;
      int q;
      mag = (k < 0) ? -k : k;
      q = (mag * (1 << frac) + 500) / 1000;
      return (k < 0) ? -q : q;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/color_space_quantizer_unit.sv -----
// ---------------------------------------------------------------------------
// color_space_quantizer_unit
// Reduces an 8-bit RGB pixel to a number of levels per channel, directly or
// by way of the YUV or YIQ space, in an eight-stage pipeline.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | csq_req_type (red, green, blue)
//   rsp     | out       | rsp_valid/stall    | csq_rsp_type (red, green, blue)
//   csr     | in        | csr_valid/ready    | csr_index, csr_data
//
// One pixel per clock when no stall holds the pipe; the result is registered.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled result holds only the full stages behind it up to the first empty one.
// After reset and after each register write the steps and reciprocals are
// rederived by a shared serial divider in six divisions, during which
// req_stall and csr_ready hold off.
// ---------------------------------------------------------------------------
`default_nettype none

module color_space_quantizer_unit #(
   parameter int COEF_FRAC_BITS = 12
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire csq_pkg::csq_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output csq_pkg::csq_rsp_type      rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [1:0]           csr_index,
   input  wire logic [8:0]           csr_data
);

`include "color_space_quantizer_unit_assert.svh"

   localparam int CW   = COEF_FRAC_BITS + 3;
   localparam int FPW  = CW + 9;
   localparam int FSW  = CW + 11;
   localparam int RSH  = COEF_FRAC_BITS - 8;
   localparam int RND  = (2 ** RSH) / 2;
   localparam int UW   = 21;
   localparam int MAGW = 20;
   localparam int PW   = MAGW + csq_pkg::MW;
   localparam int TW   = 13;
   localparam int TDW  = TW + csq_pkg::DW;
   localparam int QW   = 15;
   localparam int YMW  = QW + csq_pkg::DW + 1;
   localparam int YW   = 22;
   localparam int IPW  = CW + YW;
   localparam int ISW  = IPW + 2;
   localparam int OSH  = COEF_FRAC_BITS + 8;

   csq_pkg::csq_cfg_type cfg;

   csq_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   logic [8:1] v_ff;
   logic [8:1] v_in;
   logic [9:1] adv;

   logic                       is_cs;
   logic                       yiq;
   logic [2:0][7:0]            pix;
   logic [2:0][csq_pkg::DW-1:0] d_sel;
   logic [2:0][csq_pkg::MW-1:0] m_sel;
   logic signed [UW-1:0]       half_c [3];

   logic signed [FPW-1:0]  fp_ff [3][3];
   logic signed [FPW-1:0]  fp_in [3][3];
   logic [2:0][7:0]        pix1_ff;
   logic [2:0]             neg2_ff, neg3_ff, neg4_ff;
   logic [2:0]             neg2_in;
   logic [MAGW-1:0]        mag2_ff [3];
   logic [MAGW-1:0]        mag2_in [3];
   logic [MAGW-1:0]        mag3_ff [3];
   logic [TW-1:0]          t3_ff [3];
   logic [TW-1:0]          t3_in [3];
   logic [TW-1:0]          t4_ff [3];
   logic [MAGW-1:0]        r4_ff [3];
   logic [MAGW-1:0]        r4_in [3];
   logic signed [QW-1:0]   q5_ff [3];
   logic signed [QW-1:0]   q5_in [3];
   logic signed [YW-1:0]   y6_ff [3];
   logic signed [YW-1:0]   y6_in [3];
   logic [2:0][7:0]        rgb6_ff, rgb6_in, rgb7_ff;
   logic signed [IPW-1:0]  ip_ff [3][3];
   logic signed [IPW-1:0]  ip_in [3][3];
   csq_pkg::csq_rsp_type   rsp_ff, rsp_in;

   assign is_cs = (cfg.mode == csq_pkg::MODE_YUV) || (cfg.mode == csq_pkg::MODE_YIQ);
   assign yiq   = (cfg.mode == csq_pkg::MODE_YIQ);
   assign pix[0] = req_data.red_in;
   assign pix[1] = req_data.green_in;
   assign pix[2] = req_data.blue_in;

   // RGB mode runs all three lanes on the luma step
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_sel[i] = is_cs ? cfg.div[i] : cfg.div[0];
         m_sel[i] = is_cs ? cfg.recip[i] : cfg.recip[0];
      end
      half_c[0] = '0;
      half_c[1] = UW'(csq_pkg::HALF_TAB[yiq][0]);
      half_c[2] = UW'(csq_pkg::HALF_TAB[yiq][1]);
   end

   // stage handshake
   always_comb begin
      adv[9] = !rsp_stall;
      for (int k = 8; k >= 1; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
      v_in[1] = req_valid && !cfg.busy;
      for (int k = 2; k <= 8; k++) begin
         v_in[k] = v_ff[k-1];
      end
   end

   assign req_stall = !adv[1] || cfg.busy;
   assign rsp_valid = v_ff[8];
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= 8; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   always_comb begin
      logic signed [FSW-1:0] sum;
      logic signed [FSW-1:0] ysh;
      logic signed [UW-1:0]  u;
      logic [PW-1:0]         prod;
      logic [TDW-1:0]        td;
      logic                  ge;
      logic [TW-1:0]         t1;
      logic [MAGW-1:0]       r1;
      logic signed [QW-1:0]  tq;
      logic signed [YMW-1:0] ymul;
      logic [17:0]           rq;
      logic signed [ISW-1:0] acc;
      logic signed [ISW-1:0] ash;
      logic [2:0][7:0]       ov;
      for (int i = 0; i < 3; i++) begin
         // stage 1: forward products, both coefficient sets are constants
         for (int j = 0; j < 3; j++) begin
            fp_in[i][j] = FPW'(CW'(yiq ?
                             csq_pkg::coef_fix(csq_pkg::FWD_TAB[1][i][j], COEF_FRAC_BITS) :
                             csq_pkg::coef_fix(csq_pkg::FWD_TAB[0][i][j], COEF_FRAC_BITS)))
                          * FPW'($signed({1'b0, pix[j]}));
         end
         // stage 2: sum, round to Q10.8, chroma offset
         sum = FSW'(fp_ff[i][0]) + FSW'(fp_ff[i][1]) + FSW'(fp_ff[i][2]);
         ysh = (sum + FSW'(RND)) >>> RSH;
         u   = is_cs ? UW'(ysh) + half_c[i] : UW'({pix1_ff[i], 8'b0});
         neg2_in[i] = u[UW-1];
         mag2_in[i] = u[UW-1] ? MAGW'(-u) : MAGW'(u);
         // stage 3: quotient estimate, never above the true one
         prod     = PW'(mag2_ff[i]) * PW'(m_sel[i]);
         t3_in[i] = TW'(prod >> csq_pkg::RECIP_SHIFT);
         // stage 4: remainder
         td       = TDW'(t3_ff[i]) * TDW'(d_sel[i]);
         r4_in[i] = mag3_ff[i] - MAGW'(td);
         // stage 5: correct by one, floor for negative values
         ge = (r4_ff[i] >= MAGW'(d_sel[i]));
         t1 = ge ? t4_ff[i] + TW'(1) : t4_ff[i];
         r1 = ge ? r4_ff[i] - MAGW'(d_sel[i]) : r4_ff[i];
         tq = QW'(t1) + QW'(r1 != '0);
         q5_in[i] = neg4_ff[i] ? -tq : QW'(t1);
         // stage 6: bin midpoint
         ymul = YMW'(q5_ff[i]) * YMW'($signed({1'b0, d_sel[i]}));
         y6_in[i] = YW'(ymul + YMW'({1'b0, d_sel[i][csq_pkg::DW-1:1]}) - YMW'(half_c[i]));
         rq = 18'(q5_ff[i][8:0]) * 18'(cfg.step) + 18'(cfg.step >> 1);
         rgb6_in[i] = (rq > 18'd255) ? 8'hFF : rq[7:0];
         // stage 7: inverse products
         for (int j = 0; j < 3; j++) begin
            ip_in[i][j] = IPW'(CW'(yiq ?
                             csq_pkg::coef_fix(csq_pkg::INV_TAB[1][i][j], COEF_FRAC_BITS) :
                             csq_pkg::coef_fix(csq_pkg::INV_TAB[0][i][j], COEF_FRAC_BITS)))
                          * IPW'(y6_ff[j]);
         end
         // stage 8: sum, clamp, drop fraction
         acc = ISW'(ip_ff[i][0]) + ISW'(ip_ff[i][1]) + ISW'(ip_ff[i][2]);
         ash = acc >>> OSH;
         if (!is_cs) begin
            ov[i] = rgb7_ff[i];
         end else if (acc < 0) begin
            ov[i] = 8'd0;
         end else if (ash > ISW'(255)) begin
            ov[i] = 8'hFF;
         end else begin
            ov[i] = ash[7:0];
         end
      end
      rsp_in.red_out   = ov[0];
      rsp_in.green_out = ov[1];
      rsp_in.blue_out  = ov[2];
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         fp_ff   <= fp_in;
         pix1_ff <= pix;
      end
      if (adv[2]) begin
         neg2_ff <= neg2_in;
         mag2_ff <= mag2_in;
      end
      if (adv[3]) begin
         t3_ff   <= t3_in;
         mag3_ff <= mag2_ff;
         neg3_ff <= neg2_ff;
      end
      if (adv[4]) begin
         t4_ff   <= t3_ff;
         r4_ff   <= r4_in;
         neg4_ff <= neg3_ff;
      end
      if (adv[5]) begin
         q5_ff <= q5_in;
      end
      if (adv[6]) begin
         y6_ff   <= y6_in;
         rgb6_ff <= rgb6_in;
      end
      if (adv[7]) begin
         ip_ff   <= ip_in;
         rgb7_ff <= rgb6_ff;
      end
      if (adv[8]) begin
         rsp_ff <= rsp_in;
      end
   end

   `CSQ_ASSERT_NXT(a_csr_write_rederives, csr_valid && csr_ready, cfg.busy)
   `CSQ_ASSERT_IMP(a_steps_nonzero, !cfg.busy,
      (cfg.div[0] != '0) && (cfg.div[1] != '0) && (cfg.div[2] != '0))
   `CSQ_ASSERT_IMP(a_no_request_while_busy, cfg.busy, req_stall)
   `CSQ_ASSERT_NXT(a_request_enters_pipe, req_valid && !req_stall, v_ff[1])

endmodule

`default_nettype wire

// ----- hdl/csq_cfg.sv -----
// ---------------------------------------------------------------------------
// csq_cfg
// Configuration registers and a radix-2 divider that derives the quantiser
// steps and their reciprocals after reset and after every register write.
// ---------------------------------------------------------------------------
`default_nettype none

module csq_cfg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [1:0]           csr_index,
   input  wire logic [8:0]           csr_data,
   output csq_pkg::csq_cfg_type      cfg
);

   localparam int NW = 31;
   localparam logic [2:0] JOB_STEP     = 3'd0;
   localparam logic [2:0] JOB_CHROMA_U = 3'd1;
   localparam logic [2:0] JOB_CHROMA_V = 3'd2;
   localparam logic [2:0] JOB_RECIP_Y  = 3'd3;
   localparam logic [2:0] JOB_RECIP_U  = 3'd4;
   localparam logic [2:0] JOB_RECIP_V  = 3'd5;

   csq_pkg::csq_state_type state_ff, state_in;
   logic [1:0]                   mode_ff;
   logic [8:0]                   levels_ff;
   logic [2:0]                   job_ff;
   logic [4:0]                   cnt_ff;
   logic [csq_pkg::DW-1:0]       rem_ff;
   logic [NW-1:0]                quo_ff;
   logic [csq_pkg::DW-1:0]       den_ff;
   logic [csq_pkg::SW-1:0]       step_ff;
   logic [2:0][csq_pkg::DW-1:0]  div_ff;
   logic [2:0][csq_pkg::MW-1:0]  recip_ff;

   logic [8:0]                   lv;
   logic                         yiq;
   logic [NW-1:0]                num_sel;
   logic [csq_pkg::DW-1:0]       den_sel;
   logic [csq_pkg::DW:0]         rem_sh;
   logic                         ge;
   logic [csq_pkg::DW-1:0]       rem_in;
   logic [NW-1:0]                quo_in;
   logic                         busy;

   // levels clamped to 1..256
   always_comb begin
      if (levels_ff == 9'd0) begin
         lv = 9'd1;
      end else if (levels_ff > 9'd256) begin
         lv = 9'd256;
      end else begin
         lv = levels_ff;
      end
   end

   assign yiq = (mode_ff == csq_pkg::MODE_YIQ);

   always_comb begin
      case (job_ff)
         JOB_STEP: begin
            num_sel = NW'(256);
            den_sel = csq_pkg::DW'(lv);
         end
         JOB_CHROMA_U, JOB_CHROMA_V: begin
            num_sel = NW'(csq_pkg::RANGE_TAB[yiq][job_ff == JOB_CHROMA_V] * 256)
                      + NW'(lv) * NW'(50);
            den_sel = csq_pkg::DW'(lv) * csq_pkg::DW'(100);
         end
         JOB_RECIP_Y: begin
            num_sel = NW'(1) << csq_pkg::RECIP_SHIFT;
            den_sel = {step_ff, 8'b0};
         end
         JOB_RECIP_U: begin
            num_sel = NW'(1) << csq_pkg::RECIP_SHIFT;
            den_sel = div_ff[1];
         end
         JOB_RECIP_V: begin
            num_sel = NW'(1) << csq_pkg::RECIP_SHIFT;
            den_sel = div_ff[2];
         end
         default: begin
            num_sel = '0;
            den_sel = csq_pkg::DW'(1);
         end
      endcase
   end

   // one quotient bit a cycle
   always_comb begin
      rem_sh = {rem_ff, quo_ff[NW-1]};
      ge     = (rem_sh >= {1'b0, den_ff});
      rem_in = ge ? csq_pkg::DW'(rem_sh - {1'b0, den_ff}) : csq_pkg::DW'(rem_sh);
      quo_in = {quo_ff[NW-2:0], ge};
   end

   // next state
   always_comb begin
      case (state_ff)
         csq_pkg::ST_LOAD: state_in = csq_pkg::ST_DIV;
         csq_pkg::ST_DIV: begin
            if (cnt_ff != 5'd0) begin
               state_in = csq_pkg::ST_DIV;
            end else if (job_ff == JOB_RECIP_V) begin
               state_in = csq_pkg::ST_IDLE;
            end else begin
               state_in = csq_pkg::ST_LOAD;
            end
         end
         csq_pkg::ST_IDLE: state_in = csr_valid ? csq_pkg::ST_LOAD : csq_pkg::ST_IDLE;
         default:          state_in = csq_pkg::ST_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      case (state_ff)
         csq_pkg::ST_IDLE: begin
            busy      = 1'b0;
            csr_ready = 1'b1;
         end
         default: begin
            busy      = 1'b1;
            csr_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= csq_pkg::ST_LOAD;
         job_ff    <= JOB_STEP;
         cnt_ff    <= '0;
         mode_ff   <= csq_pkg::MODE_RGB;
         levels_ff <= 9'd8;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            csq_pkg::ST_IDLE: begin
               if (csr_valid) begin
                  job_ff <= JOB_STEP;
                  if (csr_index == csq_pkg::CSR_COLOR_MODE) begin
                     mode_ff <= csr_data[1:0];
                  end else if (csr_index == csq_pkg::CSR_LEVELS) begin
                     levels_ff <= csr_data;
                  end
               end
            end
            csq_pkg::ST_LOAD: cnt_ff <= 5'(NW - 1);
            csq_pkg::ST_DIV: begin
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd0) begin
                  job_ff <= job_ff + 3'd1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == csq_pkg::ST_LOAD) begin
         rem_ff <= '0;
         quo_ff <= num_sel;
         den_ff <= den_sel;
      end else if (state_ff == csq_pkg::ST_DIV) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         if (cnt_ff == 5'd0) begin
            case (job_ff)
               JOB_STEP:     step_ff <= quo_in[csq_pkg::SW-1:0];
               JOB_CHROMA_U: div_ff[1] <= quo_in[csq_pkg::DW-1:0];
               JOB_CHROMA_V: div_ff[2] <= quo_in[csq_pkg::DW-1:0];
               JOB_RECIP_Y: begin
                  div_ff[0]   <= {step_ff, 8'b0};
                  recip_ff[0] <= quo_in[csq_pkg::MW-1:0];
               end
               JOB_RECIP_U:  recip_ff[1] <= quo_in[csq_pkg::MW-1:0];
               JOB_RECIP_V:  recip_ff[2] <= quo_in[csq_pkg::MW-1:0];
               default: ;
            endcase
         end
      end
   end

   assign cfg.busy  = busy;
   assign cfg.mode  = mode_ff;
   assign cfg.step  = step_ff;
   assign cfg.div   = div_ff;
   assign cfg.recip = recip_ff;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for color_space_quantizer_unit. Pixels go through the
// block in RGB, YUV and YIQ modes at several level counts. Each accepted
// request is scored against a bit-true fixed-point model of the block, with
// bursty input and patterned output stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int         FRAC_C       = 12;
   localparam logic [1:0] MODE_SPARE   = 2'd3;   // unused code, behaves as RGB
   localparam int         SETTLE_CYC   = 12;

   // thousandths, [yiq][row][col]
   localparam int FWD_K [2][3][3] = '{
      '{'{299, 587, 114}, '{-147, -289, 436}, '{615, -515, -100}},
      '{'{299, 587, 114}, '{596, -274, -322}, '{211, -522, 311}}};
   localparam int INV_K [2][3][3] = '{
      '{'{1000, 0, 1140}, '{1000, -395, -581}, '{1000, 2032, 0}},
      '{'{1000, 956, 621}, '{1000, -272, -649}, '{1000, -1106, 1703}}};
   localparam longint CHROMA_RANGE [2][2] = '{'{22236, 31365}, '{30396, 26622}};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   csq_pkg::csq_req_type req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   csq_pkg::csq_rsp_type rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [1:0]           csr_index = '0;
   logic [8:0]           csr_data = '0;

   csq_pkg::csq_req_type pixels_pending [$];
   csq_pkg::csq_rsp_type quantised_due [$];
   logic [1:0]           mode_now = csq_pkg::MODE_RGB;
   logic [8:0]           levels_now = 9'd8;
   int                   mismatches = 0;

   color_space_quantizer_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data));

   always #5 clock = ~clock;

   function automatic longint fixed_coef(input int k);
      longint mag;
      longint q;
      mag = (k < 0) ? -k : k;
      q = (mag * (longint'(1) << FRAC_C) + 500) / 1000;
      return (k < 0) ? -q : q;
   endfunction

   function automatic longint div_floor(input longint v, input longint d);
      if (v >= 0) return v / d;
      return -((-v + d - 1) / d);
   endfunction

   function automatic longint bin_centre(input longint u, input longint stp);
      return div_floor(u, stp) * stp + stp / 2;
   endfunction

   function automatic csq_pkg::csq_rsp_type quantise_pixel(input logic [1:0] mode,
                                                           input logic [8:0] lev_reg,
                                                           input csq_pkg::csq_req_type px);
      longint               c [3];
      longint               y [3];
      longint               lv, stp, acc, rng, cstp, half, q;
      int                   m;
      logic [7:0]           o [3];
      csq_pkg::csq_rsp_type r;
      c[0] = px.red_in;
      c[1] = px.green_in;
      c[2] = px.blue_in;
      lv = lev_reg;
      if (lv < 1) lv = 1;
      if (lv > 256) lv = 256;
      stp = 256 / lv;
      if (mode != csq_pkg::MODE_YUV && mode != csq_pkg::MODE_YIQ) begin
         for (int i = 0; i < 3; i++) begin
            q = bin_centre(c[i], stp);
            o[i] = (q > 255) ? 8'd255 : q[7:0];
         end
      end else begin
         m = (mode == csq_pkg::MODE_YIQ) ? 1 : 0;
         for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += fixed_coef(FWD_K[m][i][j]) * c[j];
            y[i] = div_floor(acc + (1 << (FRAC_C - 9)), 1 << (FRAC_C - 8));
         end
         y[0] = bin_centre(y[0], stp << 8);
         for (int i = 1; i < 3; i++) begin
            rng  = CHROMA_RANGE[m][i-1];
            cstp = (rng * 256 + 50 * lv) / (100 * lv);
            half = (rng * 128 + 50) / 100;
            if (cstp < 1) cstp = 1;
            y[i] = bin_centre(y[i] + half, cstp) - half;
         end
         for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += fixed_coef(INV_K[m][i][j]) * y[j];
            if (acc < 0) o[i] = 8'd0;
            else begin
               acc = acc >>> (FRAC_C + 8);
               o[i] = (acc > 255) ? 8'd255 : acc[7:0];
            end
         end
      end
      r.red_out   = o[0];
      r.green_out = o[1];
      r.blue_out  = o[2];
      return r;
   endfunction

   // sender: bursts of requests with random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_valid && !req_stall)
            quantised_due.push_back(quantise_pixel(mode_now, levels_now,
                                                   pixels_pending.pop_front()));
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pixels_pending.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= pixels_pending[0];
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, in one of four styles that is redrawn at random
   int stall_style = 0;
   int stall_cyc   = 0;

   always @(posedge clock) begin
      stall_cyc <= stall_cyc + 1;
      if (stall_cyc % 256 == 255) stall_style <= $urandom_range(0, 3);
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= $urandom_range(0, 1);
         2: rsp_stall <= ($urandom_range(0, 7) == 0) ? ~rsp_stall : rsp_stall;
         default: rsp_stall <= ($urandom_range(0, 4) == 0);
      endcase
   end

   // result checker
   always @(posedge clock) begin
      csq_pkg::csq_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (quantised_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %h", rsp_data);
         end else begin
            want = quantised_due.pop_front();
            if (rsp_data.red_out !== want.red_out || rsp_data.green_out !== want.green_out
                || rsp_data.blue_out !== want.blue_out) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                           want.red_out, want.green_out, want.blue_out,
                           rsp_data.red_out, rsp_data.green_out, rsp_data.blue_out);
            end
         end
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [8:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == csq_pkg::CSR_COLOR_MODE) mode_now <= val[1:0];
      else if (idx == csq_pkg::CSR_LEVELS) levels_now <= val;
   endtask

   task automatic drain_all();
      while (pixels_pending.size() > 0 || quantised_due.size() > 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 3);
         1: return $urandom_range(252, 255);
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   task automatic queue_random(input int n);
      csq_pkg::csq_req_type px;
      for (int k = 0; k < n; k++) begin
         px.red_in   = rand_chan();
         px.green_in = rand_chan();
         px.blue_in  = rand_chan();
         pixels_pending.push_back(px);
      end
   endtask

   initial begin
      logic [1:0]           modes  [14];
      logic [8:0]           levs   [14];
      logic [7:0]           corner [2];
      csq_pkg::csq_req_type px;
      modes  = '{csq_pkg::MODE_RGB, csq_pkg::MODE_RGB, csq_pkg::MODE_YUV,
                 csq_pkg::MODE_YUV, csq_pkg::MODE_YIQ, csq_pkg::MODE_YIQ, MODE_SPARE,
                 csq_pkg::MODE_YUV, csq_pkg::MODE_YIQ, csq_pkg::MODE_YUV,
                 csq_pkg::MODE_YIQ, csq_pkg::MODE_RGB, csq_pkg::MODE_YUV,
                 csq_pkg::MODE_YIQ};
      levs   = '{9'd1, 9'd256, 9'd1, 9'd256, 9'd1, 9'd256, 9'd7,
                 9'd0, 9'd511, 9'd3, 9'd16, 9'd300, 9'd170, 9'd85};
      corner = '{8'd0, 8'd255};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // reset defaults, corner pixels plus random
      for (int k = 0; k < 8; k++) begin
         px.red_in   = corner[k[0]];
         px.green_in = corner[k[1]];
         px.blue_in  = corner[k[2]];
         pixels_pending.push_back(px);
      end
      px = '{8'd128, 8'd127, 8'd1};
      pixels_pending.push_back(px);
      px = '{8'h55, 8'hAA, 8'h0F};
      pixels_pending.push_back(px);
      queue_random(60);
      for (int p = 0; p < 14; p++) begin
         drain_all();
         write_csr(csq_pkg::CSR_COLOR_MODE, {7'd0, modes[p]});
         write_csr(csq_pkg::CSR_LEVELS, levs[p]);
         queue_random(65);
      end
      drain_all();
      if (mismatches == 0)
         $display("color_space_quantizer_unit verification clean");
      else
         $display("color_space_quantizer_unit verification failed");
      $finish;
   end

   initial begin
      #3ms;
      $display("color_space_quantizer_unit verification failed");
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hdl
hdl/csq_pkg.sv
hdl/csq_cfg.sv
hdl/color_space_quantizer_unit.sv
tb/testbench.sv
